FILE: rtl/core/bpu_pkg.sv
// shared types, constants and codes of the bmp pixel unpacker
`timescale 1ns / 1ps

package bpu_pkg;

    // image limits
    localparam int MAX_WIDTH     = 4096;
    localparam int MAX_HEIGHT    = 4096;
    localparam int PALETTE_DEPTH = 256;

    // job queue between front and back
    localparam int FIFO_DEPTH = 4;

    // pixel formats
    typedef enum logic [1:0] {
        MODE_1BIT  = 2'd0,
        MODE_4BIT  = 2'd1,
        MODE_8BIT  = 2'd2,
        MODE_24BIT = 2'd3
    } pixel_mode_t;

    // item functions
    typedef enum logic {
        FUNC_PALETTE = 1'b0,
        FUNC_PIXEL   = 1'b1
    } item_func_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_PIXEL_MODE   = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2,
        REG_TOP_DOWN     = 2'd3
    } cfg_reg_t;

    // one queued job: a palette write or the pixel run of one byte
    typedef struct packed {
        logic        is_pal;     // palette write
        logic [7:0]  pal_index;  // palette entry written
        logic [23:0] rgb;        // palette colour or direct 24-bit colour
        logic [7:0]  data_byte;  // raw pixel byte
        pixel_mode_t mode;
        logic [11:0] column;     // column of the first pixel
        logic [11:0] row;
        logic [3:0]  count;      // pixels in the run, 1 to 8
        logic        done;       // run ends the image
    } bpu_job_t;

endpackage

FILE: rtl/core/bpu_ifs.sv
// channel interfaces of the bmp pixel unpacker
`timescale 1ns / 1ps

// input items: palette writes and pixel-array bytes
interface bpu_item_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] data_byte;
    logic [7:0] entry_index;
    logic [7:0] entry_red;
    logic [7:0] entry_green;
    logic [7:0] entry_blue;

    modport source (
        output valid, func, data_byte, entry_index, entry_red, entry_green, entry_blue,
        input  ready
    );
    modport sink (
        input  valid, func, data_byte, entry_index, entry_red, entry_green, entry_blue,
        output ready
    );
endinterface

// decoded pixels
interface bpu_pixel_if;
    logic        valid;
    logic        ready;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] column;
    logic [11:0] row;
    logic        last_of_run;
    logic        image_done;

    modport source (
        output valid, red, green, blue, column, row, last_of_run, image_done,
        input  ready
    );
    modport sink (
        input  valid, red, green, blue, column, row, last_of_run, image_done,
        output ready
    );
endinterface

// configuration register writes
interface bpu_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [12:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

FILE: rtl/core/bpu_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module bpu_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/bpu_fifo.sv
// short job queue between front and back
`timescale 1ns / 1ps

module bpu_fifo import bpu_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  bpu_job_t push_job,
    output logic     push_ready,
    input  logic     pop,
    output logic     head_valid,
    output bpu_job_t head_job
);

    localparam int PW = $clog2(FIFO_DEPTH);

    bpu_job_t        slot [FIFO_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PW:0]     count_reg, count_next;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != (PW+1)'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slot[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (PW+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (PW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: rtl/core/bpu_front.sv
// front: config registers, image position counters and job building
`timescale 1ns / 1ps

module bpu_front import bpu_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    bpu_item_if.sink       item,
    bpu_cfg_if.sink        cfg,
    output logic           push,
    output bpu_job_t       push_job,
    input  logic           push_ready
);

    // configuration
    pixel_mode_t  mode_reg;
    logic [12:0]  width_reg;
    logic [12:0]  height_reg;
    logic         top_down_reg;

    // position state
    logic [13:0]  byte_reg, byte_next;
    logic [12:0]  pix_reg, pix_next;
    logic [12:0]  rows_reg, rows_next;
    logic [15:0]  partial_reg, partial_next;
    logic [1:0]   phase_reg, phase_next;
    logic         finished_reg, finished_next;

    logic         item_xfer, cfg_xfer, pix_go;
    logic [12:0]  w_eff, h_eff;
    logic [13:0]  w3, row_units, rb, byte_inc;
    logic [12:0]  room;
    logic [3:0]   n_raw, n;
    logic         emit_triple;
    logic [12:0]  rows_inc;
    logic [12:0]  row_full;

    assign item.ready = push_ready;
    assign cfg.ready  = 1'b1;
    assign item_xfer  = item.valid && item.ready;
    assign cfg_xfer   = cfg.valid && cfg.ready;
    assign pix_go     = item_xfer && (item.func == FUNC_PIXEL) && !finished_reg;

    // clamped image size
    always_comb
    begin
        if (width_reg == '0)
            w_eff = 13'd1;
        else if (width_reg > 13'(MAX_WIDTH))
            w_eff = 13'(MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg == '0)
            h_eff = 13'd1;
        else if (height_reg > 13'(MAX_HEIGHT))
            h_eff = 13'(MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    // bytes per scanline, padded to four
    always_comb
    begin
        w3 = (14'(w_eff) << 1) + 14'(w_eff);
        case (mode_reg)
            MODE_1BIT:  row_units = (14'(w_eff) + 14'd7) >> 3;
            MODE_4BIT:  row_units = (14'(w_eff) + 14'd1) >> 1;
            MODE_8BIT:  row_units = 14'(w_eff);
            default:    row_units = w3;
        endcase
        rb = (row_units + 14'd3) & ~14'd3;
    end

    // pixel count of this byte
    always_comb
    begin
        room        = (pix_reg < w_eff) ? (w_eff - pix_reg) : 13'd0;
        emit_triple = (byte_reg < w3) && (phase_reg == 2'd2);
        case (mode_reg)
            MODE_1BIT:  n_raw = 4'd8;
            MODE_4BIT:  n_raw = 4'd2;
            MODE_8BIT:  n_raw = 4'd1;
            default:    n_raw = emit_triple ? 4'd1 : 4'd0;
        endcase
        n = ({9'd0, n_raw} > room) ? room[3:0] : n_raw;
    end

    // next position
    always_comb
    begin
        byte_next     = byte_reg;
        pix_next      = pix_reg;
        rows_next     = rows_reg;
        partial_next  = partial_reg;
        phase_next    = phase_reg;
        finished_next = finished_reg;
        byte_inc      = byte_reg + 14'd1;
        rows_inc      = rows_reg + 13'd1;
        if (pix_go)
        begin
            pix_next = pix_reg + 13'(n);
            if ((mode_reg == MODE_24BIT) && (byte_reg < w3))
            begin
                case (phase_reg)
                    2'd0:
                    begin
                        partial_next = {8'd0, item.data_byte};
                        phase_next   = 2'd1;
                    end
                    2'd1:
                    begin
                        partial_next = {item.data_byte, partial_reg[7:0]};
                        phase_next   = 2'd2;
                    end
                    default:
                    begin
                        partial_next = '0;
                        phase_next   = 2'd0;
                    end
                endcase
            end
            byte_next = byte_inc;
            if (byte_inc >= rb)
            begin
                byte_next     = '0;
                pix_next      = '0;
                phase_next    = 2'd0;
                partial_next  = '0;
                rows_next     = rows_inc;
                finished_next = (rows_inc >= h_eff);
            end
        end
    end

    // job building
    always_comb
    begin
        row_full           = top_down_reg ? rows_reg : (h_eff - 13'd1 - rows_reg);
        push_job.is_pal    = (item.func == FUNC_PALETTE);
        push_job.pal_index = item.entry_index;
        push_job.data_byte = item.data_byte;
        push_job.mode      = mode_reg;
        push_job.column    = pix_reg[11:0];
        push_job.row       = row_full[11:0];
        push_job.count     = n;
        push_job.done      = (rows_inc == h_eff) && ((pix_reg + 13'(n)) == w_eff);
        if (item.func == FUNC_PALETTE)
            push_job.rgb = {item.entry_red, item.entry_green, item.entry_blue};
        else
            push_job.rgb = {item.data_byte, partial_reg};
        push = item_xfer && ((item.func == FUNC_PALETTE) || (pix_go && (n != 4'd0)));
    end

    // config and position registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_24BIT;
            width_reg    <= 13'd1;
            height_reg   <= 13'd1;
            top_down_reg <= 1'b0;
            byte_reg     <= '0;
            pix_reg      <= '0;
            rows_reg     <= '0;
            partial_reg  <= '0;
            phase_reg    <= '0;
            finished_reg <= 1'b0;
        end
        else if (cfg_xfer)
        begin
            case (cfg.index)
                REG_PIXEL_MODE:   mode_reg     <= pixel_mode_t'(cfg.data[1:0]);
                REG_IMAGE_WIDTH:  width_reg    <= cfg.data;
                REG_IMAGE_HEIGHT: height_reg   <= cfg.data;
                REG_TOP_DOWN:     top_down_reg <= cfg.data[0];
                default:          mode_reg     <= mode_reg;
            endcase
            byte_reg     <= '0;
            pix_reg      <= '0;
            rows_reg     <= '0;
            partial_reg  <= '0;
            phase_reg    <= '0;
            finished_reg <= 1'b0;
        end
        else
        begin
            byte_reg     <= byte_next;
            pix_reg      <= pix_next;
            rows_reg     <= rows_next;
            partial_reg  <= partial_next;
            phase_reg    <= phase_next;
            finished_reg <= finished_next;
        end
    end

`ifndef SYNTHESIS
    // image complete only after exactly the configured number of rows
    assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |-> (rows_reg == h_eff))
        else $error("finished with wrong row count");

    // scanline byte counter wraps at the padded row length
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_reg < rb)
        else $error("byte counter beyond padded row");

    // column never runs past the image width
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_reg <= w_eff)
        else $error("column beyond image width");

    // bytes after the end of the image are dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        (finished_reg && item_xfer && (item.func == FUNC_PIXEL)) |-> !push)
        else $error("job queued after image end");
`endif

endmodule

FILE: rtl/core/bpu_back.sv
// back: palette store, run expansion and pixel output register
`timescale 1ns / 1ps

module bpu_back import bpu_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  bpu_job_t    head_job,
    output logic        pop,
    bpu_pixel_if.source pixel
);

    localparam int AW = $clog2(PALETTE_DEPTH);

    logic [2:0]   k_reg, k_next;
    logic         ob_valid_reg, ob_valid_next;
    logic         ob_use_pal_reg;
    logic [23:0]  ob_rgb_reg;
    logic [11:0]  ob_column_reg;
    logic [11:0]  ob_row_reg;
    logic         ob_last_reg;
    logic         ob_done_reg;

    logic         adv, pal_wr, pix_issue, last_k;
    logic [7:0]   rd_index;
    logic [7:0]   shifted;
    logic [23:0]  pal_rgb;

    assign adv       = !ob_valid_reg || pixel.ready;
    assign pal_wr    = head_valid && head_job.is_pal;
    assign pix_issue = head_valid && !head_job.is_pal && adv;
    assign last_k    = (({1'b0, k_reg} + 4'd1) == head_job.count);
    assign pop       = pal_wr || (pix_issue && last_k);

    // palette index of pixel k, msb first
    always_comb
    begin
        shifted = head_job.data_byte << k_reg;
        case (head_job.mode)
            MODE_1BIT:  rd_index = {7'd0, shifted[7]};
            MODE_4BIT:  rd_index = k_reg[0] ? {4'd0, head_job.data_byte[3:0]}
                                            : {4'd0, head_job.data_byte[7:4]};
            default:    rd_index = head_job.data_byte;
        endcase
    end

    bpu_ram #(
        .WIDTH (24),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk     (clk),
        .wr_en   (pal_wr),
        .wr_addr (head_job.pal_index[AW-1:0]),
        .wr_data (head_job.rgb),
        .rd_en   (pix_issue),
        .rd_addr (rd_index[AW-1:0]),
        .rd_data (pal_rgb)
    );

    // run position and output valid
    always_comb
    begin
        k_next = k_reg;
        if (pix_issue)
        begin
            k_next = last_k ? 3'd0 : k_reg + 3'd1;
        end
        if (pix_issue)
            ob_valid_next = 1'b1;
        else if (pixel.ready)
            ob_valid_next = 1'b0;
        else
            ob_valid_next = ob_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg        <= '0;
            ob_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg        <= k_next;
            ob_valid_reg <= ob_valid_next;
        end
    end

    // output pixel fields
    always_ff @(posedge clk)
    begin
        if (pix_issue)
        begin
            ob_use_pal_reg <= (head_job.mode != MODE_24BIT);
            ob_rgb_reg     <= head_job.rgb;
            ob_column_reg  <= head_job.column + 12'(k_reg);
            ob_row_reg     <= head_job.row;
            ob_last_reg    <= last_k;
            ob_done_reg    <= last_k && head_job.done;
        end
    end

    assign pixel.valid       = ob_valid_reg;
    assign pixel.red         = ob_use_pal_reg ? pal_rgb[23:16] : ob_rgb_reg[23:16];
    assign pixel.green       = ob_use_pal_reg ? pal_rgb[15:8]  : ob_rgb_reg[15:8];
    assign pixel.blue        = ob_use_pal_reg ? pal_rgb[7:0]   : ob_rgb_reg[7:0];
    assign pixel.column      = ob_column_reg;
    assign pixel.row         = ob_row_reg;
    assign pixel.last_of_run = ob_last_reg;
    assign pixel.image_done  = ob_done_reg;

`ifndef SYNTHESIS
    // a run never indexes past its pixel count
    assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid && !head_job.is_pal) |-> ({1'b0, k_reg} < head_job.count))
        else $error("run index beyond pixel count");

    // end of image is always the last pixel of its run
    assert property (@(posedge clk) disable iff (!rst_n)
        (pixel.valid && pixel.image_done) |-> pixel.last_of_run)
        else $error("image end inside a run");

    // a palette write never waits on the output side
    assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid && head_job.is_pal) |-> pop)
        else $error("palette write not retired");
`endif

endmodule

FILE: rtl/core/bmp_pixel_unpacker_top.sv
// top level of the bmp pixel unpacker
//
//  channel  role    transfer carries
//  item     sink    one palette entry write or one pixel-array byte
//  pixel    source  one decoded pixel with column, row and run flags
//  cfg      sink    one register write: index, data (always ready)
//
// pixels leave at one per cycle while pixel is ready, set by the single palette read
// port; a byte yields at most 8 pixels in one-bit mode, 2 in four-bit, 1 otherwise
// bytes that yield nothing are not queued; palette writes retire at the queue head
// a four-entry job queue lets the front accept bytes while the back drains a run
// reset clears counters and config to defaults; the palette holds no reset value
// item ready drops only while the job queue is full
`timescale 1ns / 1ps

module bmp_pixel_unpacker_top import bpu_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    bpu_item_if.sink    item,
    bpu_cfg_if.sink     cfg,
    bpu_pixel_if.source pixel
);

    logic     push, push_ready, pop, head_valid;
    bpu_job_t push_job, head_job;

    // position tracking and job building
    bpu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .cfg        (cfg),
        .push       (push),
        .push_job   (push_job),
        .push_ready (push_ready)
    );

    // job queue
    bpu_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .push_ready (push_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // palette and pixel output
    bpu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .pixel      (pixel)
    );

endmodule
